>>> rtl/itoa_pkg.sv
// Shared types, constants and helper functions for the integer to ASCII formatter.
// Used by the divider and the top-level sequencer; no dependencies.
package itoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_WIDTH_DEF  = 64;

  localparam int VALUE_W  = 32;  // width of the value port
  localparam int FW_W     = 7;   // field width and pad counters
  localparam int DIGIT_W  = 4;
  localparam int RADIX_W  = 5;
  localparam int DIV_STEP = 8;   // dividend bits consumed per divider cycle
  localparam int CHAR_W   = 8;

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] radix;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_sts_t;

  function automatic logic [RADIX_W-1:0] radix_of(input logic [1:0] sel);
    logic [RADIX_W-1:0] r;
    case (sel)
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      BASE_DEC: r = 5'd10;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else if (upper) begin
      c = CH_UPPER_A + CHAR_W'(d - 4'd10);
    end else begin
      c = CH_LOWER_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> rtl/itoa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/itoa_div.sv
// Iterative divider by a small radix: eight restoring steps per cycle.
// Depends on itoa_pkg for the request and status structs.
module itoa_div #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  itoa_pkg::div_req_t      req,
  input  logic [VALUE_BITS-1:0]   dividend,
  output itoa_pkg::div_sts_t      sts,
  output logic [VALUE_BITS-1:0]   quotient
);
  import itoa_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int WORK_W = CHUNKS * DIV_STEP;
  localparam int CW     = $clog2(CHUNKS + 1);

  logic [WORK_W-1:0]  work_r, work_nxt, step_work;
  logic [DIGIT_W-1:0] rem_r, rem_nxt, step_rem;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;

  // one chunk of long division, most significant bit first
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [DIV_STEP-1:0] qb;
    r  = {1'b0, rem_r};
    qb = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      r = {r[DIGIT_W-1:0], work_r[WORK_W-1-i]};
      if (r >= radix_r) begin
        r = r - radix_r;
        qb[DIV_STEP-1-i] = 1'b1;
      end
    end
    step_rem  = r[DIGIT_W-1:0];
    step_work = (work_r << DIV_STEP) | WORK_W'(qb);
  end

  always_comb begin
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      work_nxt  = WORK_W'(dividend);
      rem_nxt   = '0;
      radix_nxt = req.radix;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      work_nxt = step_work;
      rem_nxt  = step_rem;
      cnt_nxt  = cnt_r + CW'(1);
      if (cnt_r == CW'(CHUNKS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  assign quotient = work_r[VALUE_BITS-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.rem  = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start && cnt_r == CW'(CHUNKS - 1) |=> done_r)
    else $error("divider missed its done pulse");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < radix_r)
    else $error("remainder not below radix");

endmodule

>>> rtl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter: sequencer, digit store and output register.
// Depends on itoa_pkg, itoa_div and itoa_ram.
// Digits come from the shared divider, restarted on each quotient until it is zero or the
// store is full; each remainder goes to the digit store and is read back most significant first.
// Output: one character per cycle while the output is not stalled; no new request
// is accepted until the last character has been emitted.
// Reset (synchronous, rst_n low) idles the sequencer and divider and empties the output.
module integer_to_ascii_formatter_unit #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = itoa_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [itoa_pkg::VALUE_W-1:0]  in_value,
  input  logic [1:0]                    in_base_select,
  input  logic                          in_is_signed,
  input  logic [itoa_pkg::FW_W-1:0]     in_field_width,
  input  logic                          in_left_align,
  input  logic                          in_zero_pad,
  input  logic                          in_plus_sign,
  input  logic                          in_space_sign,
  input  logic                          in_uppercase,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);
  import itoa_pkg::*;

  localparam int ADDR_W = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int EC_W   = $clog2(MAX_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WAIT, S_FETCH, S_PAD, S_SIGN, S_DIGITS, S_TRAIL
  } state_t;

  state_t              state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [1:0]          base_r, base_nxt;
  logic                upper_r, upper_nxt, left_r, left_nxt, zero_r, zero_nxt;
  logic                has_sign_r, has_sign_nxt;
  logic [CHAR_W-1:0]   sign_char_r, sign_char_nxt;
  logic [FW_W-1:0]     width_r, width_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FW_W-1:0]     pad_r, pad_nxt;
  logic [EC_W-1:0]     emit_cnt_r, emit_cnt_nxt;
  logic                out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;

  div_req_t              div_req;
  div_sts_t              div_sts;
  logic [VALUE_BITS-1:0] dividend, quotient;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DIGIT_W-1:0]  ram_rdata;

  logic [VALUE_BITS-1:0] v_ext;
  logic                neg, adv, trunc, fin;
  logic [CNT_W-1:0]    count_inc, count_m1, count_m2;
  logic [FW_W-1:0]     len;

  itoa_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (dividend),
    .sts      (div_sts),
    .quotient (quotient)
  );

  itoa_ram #(.WIDTH(DIGIT_W), .DEPTH(VALUE_BITS)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (div_sts.rem),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign v_ext     = VALUE_BITS'(in_value);
  assign neg       = in_is_signed && v_ext[VALUE_BITS-1];
  assign adv       = !out_valid_r || !out_stall;
  assign trunc     = (emit_cnt_r == EC_W'(MAX_WIDTH - 1));
  assign count_inc = count_r + CNT_W'(1);
  assign count_m1  = count_r - CNT_W'(1);
  assign count_m2  = count_r - CNT_W'(2);
  assign len       = FW_W'(count_inc) + FW_W'(has_sign_r);
  assign fin       = (count_r == CNT_W'(1)) && (pad_r == '0);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    base_nxt      = base_r;
    upper_nxt     = upper_r;
    left_nxt      = left_r;
    zero_nxt      = zero_r;
    has_sign_nxt  = has_sign_r;
    sign_char_nxt = sign_char_r;
    width_nxt     = width_r;
    count_nxt     = count_r;
    pad_nxt       = pad_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_req.start = 1'b0;
    div_req.radix = radix_of(base_r);
    dividend      = mag_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = count_m1[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt      = neg ? (~v_ext) + VALUE_BITS'(1) : v_ext;
          base_nxt     = in_base_select;
          upper_nxt    = in_uppercase;
          left_nxt     = in_left_align;
          zero_nxt     = in_zero_pad;
          has_sign_nxt = neg || in_plus_sign || in_space_sign;
          if (neg) begin
            sign_char_nxt = CH_MINUS;
          end else if (in_plus_sign) begin
            sign_char_nxt = CH_PLUS;
          end else begin
            sign_char_nxt = CH_SPACE;
          end
          width_nxt    = (in_field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH)
                                                             : in_field_width;
          count_nxt    = '0;
          emit_cnt_nxt = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_sts.done) begin
          ram_we    = 1'b1;
          count_nxt = count_inc;
          if (quotient == '0 || count_inc == CNT_W'(VALUE_BITS)) begin
            pad_nxt   = (width_r > len) ? width_r - len : '0;
            state_nxt = S_FETCH;
          end else begin
            // chain the next digit straight off the quotient
            div_req.start = 1'b1;
            dividend      = quotient;
          end
        end
      end
      S_FETCH: begin
        ram_re = 1'b1;
        if (!left_r && pad_r != '0) begin
          state_nxt = S_PAD;
        end else if (has_sign_r) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIGITS;
        end
      end
      S_PAD: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = zero_r ? CH_ZERO : CH_SPACE;
          out_last_nxt  = trunc;
          emit_cnt_nxt  = emit_cnt_r + EC_W'(1);
          pad_nxt       = pad_r - FW_W'(1);
          if (trunc) begin
            state_nxt = S_IDLE;
          end else if (pad_r == FW_W'(1)) begin
            state_nxt = has_sign_r ? S_SIGN : S_DIGITS;
          end
        end
      end
      S_SIGN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sign_char_r;
          out_last_nxt  = trunc;
          emit_cnt_nxt  = emit_cnt_r + EC_W'(1);
          state_nxt     = trunc ? S_IDLE : S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(ram_rdata, upper_r);
          out_last_nxt  = trunc || fin;
          emit_cnt_nxt  = emit_cnt_r + EC_W'(1);
          count_nxt     = count_m1;
          // prefetch the next digit down
          if (count_r != CNT_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = count_m2[ADDR_W-1:0];
          end
          if (trunc || fin) begin
            state_nxt = S_IDLE;
          end else if (count_r == CNT_W'(1)) begin
            state_nxt = S_TRAIL;
          end
        end
      end
      S_TRAIL: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_SPACE;
          out_last_nxt  = trunc || (pad_r == FW_W'(1));
          emit_cnt_nxt  = emit_cnt_r + EC_W'(1);
          pad_nxt       = pad_r - FW_W'(1);
          if (trunc || pad_r == FW_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      pad_r       <= '0;
      emit_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      pad_r       <= pad_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
    end
    mag_r       <= mag_nxt;
    base_r      <= base_nxt;
    upper_r     <= upper_nxt;
    left_r      <= left_nxt;
    zero_r      <= zero_nxt;
    has_sign_r  <= has_sign_nxt;
    sign_char_r <= sign_char_nxt;
    width_r     <= width_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DIV)
    else $error("accepted request did not start division");

  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIGITS |-> count_r != '0)
    else $error("digit phase with empty digit store");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !div_sts.busy)
    else $error("divider busy while ready for a request");

endmodule
